FILE: design/hdma_indirect_channel_macros.svh
// Assertion macros used by the checker file of the HDMA indirect channel.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef HDMA_INDIRECT_CHANNEL_MACROS_SVH
`define HDMA_INDIRECT_CHANNEL_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define HDI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define HDI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hdi_pkg.sv
// Types, codes and constants of the HDMA indirect channel.
// No dependencies; used by every other file of the block but the macros header.
package hdi_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [15:0] DST_BASE   = 16'h2100;
  localparam logic [6:0]  COUNT_MASK = 7'h7F;

  typedef enum logic [1:0] {
    FUNC_INIT = 2'd0,
    FUNC_LINE = 2'd1,
    FUNC_DATA = 2'd2,
    FUNC_RSVD = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_COPY  = 2'd1,
    OP_IDLE  = 2'd2,
    OP_ERROR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_TABLE_START   = 2'd0,
    REG_TABLE_BANK    = 2'd1,
    REG_INDIRECT_BANK = 2'd2,
    REG_B_REGISTER    = 2'd3
  } reg_idx_t;

  // Which table byte the channel waits for.
  typedef enum logic [7:0] {
    AW_NONE      = 8'b0000_0001,
    AW_INIT_CNT  = 8'b0000_0010,
    AW_INIT_LOW  = 8'b0000_0100,
    AW_INIT_HIGH = 8'b0000_1000,
    AW_LINE_CNT  = 8'b0001_0000,
    AW_TERM_HIGH = 8'b0010_0000,
    AW_LINE_LOW  = 8'b0100_0000,
    AW_LINE_HIGH = 8'b1000_0000
  } await_t;

  // One classified item: an optional copy pair followed by a final result.
  typedef struct packed {
    op_t         op;
    logic [23:0] src;
    logic        copy;
    logic [23:0] copy_src;
    logic [15:0] copy_dst;
  } job_t;

endpackage

FILE: design/hdi_in_if.sv
// Input channel of the HDMA indirect channel: events and returned table bytes.
// Depends on hdi_pkg.
interface hdi_in_if;
  import hdi_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data;
  logic       enabled;

  modport source (output valid, output func, output data, output enabled, input ready);
  modport sink   (input valid, input func, input data, input enabled, output ready);
endinterface

FILE: design/hdi_out_if.sv
// Result channel of the HDMA indirect channel: read, copy and status results.
// Depends on hdi_pkg.
interface hdi_out_if;
  import hdi_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] src_address;
  logic [15:0] dst_address;
  logic        last;

  modport source (output valid, output op, output src_address, output dst_address,
                  output last, input ready);
  modport sink   (input valid, input op, input src_address, input dst_address,
                  input last, output ready);
endinterface

FILE: design/hdi_front.sv
// Front part: configuration registers, channel state and item classification.
// Depends on hdi_pkg and hdi_in_if; pushes one job per answering item.
module hdi_front (
  input  logic                             clk,
  input  logic                             rst_n,
  hdi_in_if.sink                           in_chan,
  input  logic                             cfg_we,
  input  logic [hdi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             q_full,
  output logic                             q_push,
  output hdi_pkg::job_t                    q_job
);
  import hdi_pkg::*;

  logic [15:0] start_r;
  logic [7:0]  tbank_r, ibank_r, breg_r;

  logic [15:0] tp_r, tp_nxt;
  logic [7:0]  lc_r, lc_nxt;
  logic [15:0] ip_r, ip_nxt;
  logic        xfer_r, xfer_nxt;
  logic        fin_r, fin_nxt;
  logic        init_r, init_nxt;
  await_t      await_r, await_nxt;
  logic [7:0]  low_r, low_nxt;

  logic        accept;
  logic        push;
  job_t        job;
  logic [15:0] tp_inc;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign tp_inc        = tp_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      tbank_r <= '0;
      ibank_r <= '0;
      breg_r  <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TABLE_START:   start_r <= cfg_wdata;
        REG_TABLE_BANK:    tbank_r <= cfg_wdata[7:0];
        REG_INDIRECT_BANK: ibank_r <= cfg_wdata[7:0];
        REG_B_REGISTER:    breg_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tp_nxt    = tp_r;
    lc_nxt    = lc_r;
    ip_nxt    = ip_r;
    xfer_nxt  = xfer_r;
    fin_nxt   = fin_r;
    init_nxt  = init_r;
    await_nxt = await_r;
    low_nxt   = low_r;
    push      = 1'b0;
    job.op       = OP_IDLE;
    job.src      = '0;
    job.copy     = 1'b0;
    job.copy_src = {ibank_r, ip_r};
    job.copy_dst = DST_BASE + {8'h00, breg_r};

    case (func_t'(in_chan.func))
      FUNC_INIT: begin
        push      = 1'b1;
        fin_nxt   = 1'b0;
        xfer_nxt  = 1'b0;
        init_nxt  = 1'b0;
        await_nxt = AW_NONE;
        if (in_chan.enabled) begin
          tp_nxt    = start_r;
          xfer_nxt  = 1'b1;
          job.op    = OP_READ;
          job.src   = {tbank_r, start_r};
          await_nxt = AW_INIT_CNT;
        end
      end
      FUNC_LINE: begin
        push = 1'b1;
        if (!in_chan.enabled || (init_r && fin_r && await_r == AW_NONE)) begin
          job.op = OP_IDLE;
        end else if (!init_r || await_r != AW_NONE) begin
          job.op = OP_ERROR;
        end else begin
          // The copy pair reads the pointer before it advances by two.
          job.copy = xfer_r;
          if (xfer_r) begin
            ip_nxt = ip_r + 16'd2;
          end
          lc_nxt    = lc_r - 8'd1;
          xfer_nxt  = lc_nxt[7];
          job.op    = OP_READ;
          job.src   = {tbank_r, tp_r};
          await_nxt = AW_LINE_CNT;
        end
      end
      FUNC_DATA: begin
        case (await_r)
          AW_INIT_CNT: begin
            push      = 1'b1;
            lc_nxt    = in_chan.data;
            tp_nxt    = tp_inc;
            if (in_chan.data == 8'd0) begin
              fin_nxt = 1'b1;
            end
            job.op    = OP_READ;
            job.src   = {tbank_r, tp_inc};
            await_nxt = AW_INIT_LOW;
          end
          AW_INIT_LOW: begin
            push   = 1'b1;
            tp_nxt = tp_inc;
            if (fin_r) begin
              // Terminated table: the lone byte is the high pointer byte.
              ip_nxt    = {in_chan.data, 8'h00};
              init_nxt  = 1'b1;
              await_nxt = AW_NONE;
              job.op    = OP_IDLE;
            end else begin
              low_nxt   = in_chan.data;
              job.op    = OP_READ;
              job.src   = {tbank_r, tp_inc};
              await_nxt = AW_INIT_HIGH;
            end
          end
          AW_INIT_HIGH, AW_LINE_HIGH: begin
            push   = 1'b1;
            tp_nxt = tp_inc;
            ip_nxt = {in_chan.data, low_r};
            if (await_r == AW_INIT_HIGH) begin
              init_nxt = 1'b1;
            end else begin
              xfer_nxt = 1'b1;
            end
            await_nxt = AW_NONE;
            job.op    = OP_IDLE;
          end
          AW_LINE_CNT: begin
            push = 1'b1;
            if ((lc_r[6:0] & COUNT_MASK) == 7'd0) begin
              lc_nxt    = in_chan.data;
              tp_nxt    = tp_inc;
              job.op    = OP_READ;
              job.src   = {tbank_r, tp_inc};
              await_nxt = (in_chan.data == 8'd0) ? AW_TERM_HIGH : AW_LINE_LOW;
            end else begin
              await_nxt = AW_NONE;
              job.op    = OP_IDLE;
            end
          end
          AW_TERM_HIGH: begin
            push      = 1'b1;
            tp_nxt    = tp_inc;
            ip_nxt    = {in_chan.data, 8'h00};
            fin_nxt   = 1'b1;
            xfer_nxt  = 1'b1;
            await_nxt = AW_NONE;
            job.op    = OP_IDLE;
          end
          AW_LINE_LOW: begin
            push      = 1'b1;
            low_nxt   = in_chan.data;
            tp_nxt    = tp_inc;
            job.op    = OP_READ;
            job.src   = {tbank_r, tp_inc};
            await_nxt = AW_LINE_HIGH;
          end
          // Nothing awaited: drop the byte.
          default: push = 1'b0;
        endcase
      end
      default: begin
        push   = 1'b1;
        job.op = OP_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r    <= '0;
      lc_r    <= '0;
      ip_r    <= '0;
      xfer_r  <= 1'b0;
      fin_r   <= 1'b0;
      init_r  <= 1'b0;
      await_r <= AW_NONE;
      low_r   <= '0;
    end else if (accept) begin
      tp_r    <= tp_nxt;
      lc_r    <= lc_nxt;
      ip_r    <= ip_nxt;
      xfer_r  <= xfer_nxt;
      fin_r   <= fin_nxt;
      init_r  <= init_nxt;
      await_r <= await_nxt;
      low_r   <= low_nxt;
    end
  end

  assign q_push = accept && push;
  assign q_job  = job;

endmodule

FILE: design/hdi_queue.sv
// Job queue between the front and back parts of the HDMA indirect channel.
// Depends on hdi_pkg for the job type.
module hdi_queue #(
  parameter int unsigned DEPTH = hdi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hdi_pkg::job_t push_job,
  output logic          full,
  output logic          valid,
  output hdi_pkg::job_t head_job,
  input  logic          pop
);
  import hdi_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign head_job = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: design/hdi_back.sv
// Back part: expands queued jobs into result transactions through an output register.
// Depends on hdi_pkg and hdi_out_if.
module hdi_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  hdi_pkg::job_t q_job,
  output logic          q_pop,
  hdi_out_if.source     out_chan
);
  import hdi_pkg::*;

  logic        valid_r, valid_nxt;
  logic [1:0]  beat_r, beat_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [23:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic        last_r, last_nxt;
  logic        advance;

  assign advance = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    op_nxt    = op_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (advance) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        if (q_job.copy && beat_r == 2'd0) begin
          op_nxt   = OP_COPY;
          src_nxt  = q_job.copy_src;
          dst_nxt  = q_job.copy_dst;
          last_nxt = 1'b0;
          beat_nxt = 2'd1;
        end else if (q_job.copy && beat_r == 2'd1) begin
          // Second byte comes from the next address within the bank.
          op_nxt   = OP_COPY;
          src_nxt  = {q_job.copy_src[23:16], q_job.copy_src[15:0] + 16'd1};
          dst_nxt  = q_job.copy_dst;
          last_nxt = 1'b0;
          beat_nxt = 2'd2;
        end else begin
          op_nxt   = q_job.op;
          src_nxt  = q_job.src;
          dst_nxt  = '0;
          last_nxt = 1'b1;
          beat_nxt = 2'd0;
          q_pop    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    last_r <= last_nxt;
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.op          = op_r;
  assign out_chan.src_address = src_r;
  assign out_chan.dst_address = dst_r;
  assign out_chan.last        = last_r;

endmodule

FILE: design/hdma_indirect_channel.sv
// HDMA indirect channel (mode 2), top level: front, job queue and back part.
// Depends on hdi_pkg, hdi_in_if, hdi_out_if, hdi_front, hdi_queue and hdi_back.
//
// The channel takes one input transaction per cycle while its job queue has
// room (QUEUE_DEPTH jobs); the front updates table pointer, line counter,
// indirect pointer and flags in the cycle of acceptance. The back part sends
// one result per cycle from its output register while the receiver is ready;
// each item's results reach that register through the job queue: a scanline
// that copies yields three results, every other answering item one, and a
// table byte arriving with no read outstanding yields none. The output port
// sets the sustained rate: one item per cycle when each causes at most one
// result and the receiver is ready; a copying scanline holds the queue head
// through its three results. Configuration writes take effect at the next edge.
module hdma_indirect_channel #(
  parameter int unsigned QUEUE_DEPTH = hdi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hdi_in_if.sink                           in_chan,
  hdi_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [hdi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hdi_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  job_t push_job, head_job;

  hdi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  hdi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .valid    (q_valid),
    .head_job (head_job),
    .pop      (q_pop)
  );

  hdi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (head_job),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: design/hdi_checker.sv
// Port-level checks of the HDMA indirect channel's result channel, bound to the top.
// Depends on hdi_pkg and hdma_indirect_channel_macros.svh.
`include "hdma_indirect_channel_macros.svh"

module hdi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_op,
  input logic [23:0] out_src,
  input logic [15:0] out_dst,
  input logic        out_last
);
  import hdi_pkg::*;

  logic [42:0] out_bus;
  logic        stalled;
  logic        copy_beat;
  logic        copy_taken;
  logic        final_beat;
  logic        on_page;

  assign out_bus    = {out_op, out_src, out_dst, out_last};
  assign stalled    = out_valid && !out_ready;
  assign copy_beat  = out_valid && (out_op == OP_COPY);
  assign copy_taken = copy_beat && out_ready;
  assign final_beat = out_valid && (out_op != OP_COPY);
  assign on_page    = (out_dst[15:8] == DST_BASE[15:8]);

  `HDI_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(out_bus), "stalled result changed")
  `HDI_ASSERT_NOW(a_copy_not_last, copy_beat, !out_last && on_page, "bad copy result")
  `HDI_ASSERT_NOW(a_final_last, final_beat, out_last && out_dst == 16'h0000, "bad final result")
  // A copy never ends the item, so another result follows at once.
  `HDI_ASSERT_NEXT(a_copy_pair, copy_taken, out_valid, "copy not followed by a result")
endmodule

bind hdma_indirect_channel hdi_checker u_hdi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_op    (out_chan.op),
  .out_src   (out_chan.src_address),
  .out_dst   (out_chan.dst_address),
  .out_last  (out_chan.last)
);

FILE: bench/tb_top.sv
// Self-checking bench for hdma_indirect_channel: directed table walk, then random
// event/table-byte streams checked against a cycle-free channel predictor.
// Depends on hdi_pkg, hdi_in_if, hdi_out_if and the hdma_indirect_channel RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdi_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned IDLE_PCT        = 26;
  localparam int unsigned PHASE_ITEMS     = 45;

  typedef struct packed {
    op_t         op;
    logic [23:0] src;
    logic [15:0] dst;
    logic        last;
  } bus_result_t;

  typedef struct packed {
    func_t      fn;
    logic [7:0] data;
    logic       en;
    logic       typed;
    op_t        op;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hdi_in_if  in_ch ();
  hdi_out_if out_ch ();

  hdma_indirect_channel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of configuration and channel state
  logic [15:0] cfg_table_start;
  logic [7:0]  cfg_table_bank;
  logic [7:0]  cfg_ind_bank;
  logic [7:0]  cfg_breg;
  logic [15:0] tbl_ptr;
  logic [7:0]  line_cnt;
  logic [15:0] ind_ptr;
  logic        xfer_on;
  logic        finished;
  logic        inited;
  await_t      wait_on;
  logic [7:0]  low_hold;

  bus_result_t step_results[$];
  bus_result_t awaited_results[$];
  bus_result_t seen_exp;

  int unsigned mismatches;
  int unsigned cycle_count;
  bit          calm;
  bit          hold_off_req;

  dir_row_t directed_rows [0:24] = '{
    '{FUNC_LINE, 8'h00, 1'b1, 1'b1, OP_ERROR},  // scanline before any init
    '{FUNC_LINE, 8'h00, 1'b0, 1'b1, OP_IDLE},
    '{FUNC_RSVD, 8'hFF, 1'b1, 1'b1, OP_ERROR},
    '{FUNC_DATA, 8'h55, 1'b1, 1'b0, OP_IDLE},   // stray byte, no result
    '{FUNC_INIT, 8'h00, 1'b0, 1'b1, OP_IDLE},
    '{FUNC_INIT, 8'h00, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_LINE, 8'h00, 1'b1, 1'b1, OP_ERROR},  // read still outstanding
    '{FUNC_DATA, 8'h81, 1'b0, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'h34, 1'b0, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'h12, 1'b0, 1'b0, OP_IDLE},
    '{FUNC_LINE, 8'h00, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'h02, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'hFF, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'hFF, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_LINE, 8'hFF, 1'b1, 1'b0, OP_IDLE},   // indirect pointer wraps
    '{FUNC_DATA, 8'h00, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_LINE, 8'h00, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'h00, 1'b1, 1'b0, OP_IDLE},   // zero counter ends the table
    '{FUNC_DATA, 8'hFF, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_LINE, 8'h00, 1'b1, 1'b1, OP_IDLE},
    '{FUNC_INIT, 8'h00, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_DATA, 8'h00, 1'b1, 1'b0, OP_IDLE},   // zero counter at init
    '{FUNC_DATA, 8'h80, 1'b1, 1'b0, OP_IDLE},
    '{FUNC_LINE, 8'h00, 1'b1, 1'b1, OP_IDLE},
    '{FUNC_LINE, 8'h00, 1'b0, 1'b1, OP_IDLE}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [23:0] table_addr();
    return {cfg_table_bank, tbl_ptr};
  endfunction

  function automatic void note_result(op_t op, logic [23:0] src, logic [15:0] dst);
    bus_result_t r;
    r.op   = op;
    r.src  = src;
    r.dst  = dst;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  // Update channel state for one accepted transaction; results go to step_results.
  task automatic advance_channel(input func_t fn, input logic [7:0] d, input logic en);
    bus_result_t r;
    step_results.delete();
    case (fn)
      FUNC_INIT: begin
        finished = 1'b0;
        xfer_on  = 1'b0;
        inited   = 1'b0;
        wait_on  = AW_NONE;
        if (!en) begin
          note_result(OP_IDLE, '0, '0);
        end else begin
          tbl_ptr = cfg_table_start;
          xfer_on = 1'b1;
          note_result(OP_READ, table_addr(), '0);
          wait_on = AW_INIT_CNT;
        end
      end
      FUNC_LINE: begin
        if (!en || (inited && finished && wait_on == AW_NONE)) begin
          note_result(OP_IDLE, '0, '0);
        end else if (!inited || wait_on != AW_NONE) begin
          note_result(OP_ERROR, '0, '0);
        end else begin
          if (xfer_on) begin
            repeat (2) begin
              note_result(OP_COPY, {cfg_ind_bank, ind_ptr}, DST_BASE + {8'h00, cfg_breg});
              ind_ptr = ind_ptr + 16'd1;
            end
          end
          line_cnt = line_cnt - 8'd1;
          xfer_on  = line_cnt[7];
          note_result(OP_READ, table_addr(), '0);
          wait_on = AW_LINE_CNT;
        end
      end
      FUNC_DATA: begin
        case (wait_on)
          AW_INIT_CNT: begin
            line_cnt = d;
            tbl_ptr  = tbl_ptr + 16'd1;
            if (d == 8'h00) finished = 1'b1;
            note_result(OP_READ, table_addr(), '0);
            wait_on = AW_INIT_LOW;
          end
          AW_INIT_LOW: begin
            tbl_ptr = tbl_ptr + 16'd1;
            if (finished) begin
              // empty table: the low byte lands in the high half
              ind_ptr = {d, 8'h00};
              inited  = 1'b1;
              wait_on = AW_NONE;
              note_result(OP_IDLE, '0, '0);
            end else begin
              low_hold = d;
              note_result(OP_READ, table_addr(), '0);
              wait_on = AW_INIT_HIGH;
            end
          end
          AW_INIT_HIGH, AW_LINE_HIGH: begin
            tbl_ptr = tbl_ptr + 16'd1;
            ind_ptr = {d, low_hold};
            if (wait_on == AW_INIT_HIGH) inited = 1'b1;
            else xfer_on = 1'b1;
            wait_on = AW_NONE;
            note_result(OP_IDLE, '0, '0);
          end
          AW_LINE_CNT: begin
            if (line_cnt[6:0] == 7'h00) begin
              line_cnt = d;
              tbl_ptr  = tbl_ptr + 16'd1;
              note_result(OP_READ, table_addr(), '0);
              wait_on = (d == 8'h00) ? AW_TERM_HIGH : AW_LINE_LOW;
            end else begin
              wait_on = AW_NONE;
              note_result(OP_IDLE, '0, '0);
            end
          end
          AW_TERM_HIGH: begin
            tbl_ptr  = tbl_ptr + 16'd1;
            ind_ptr  = {d, 8'h00};
            finished = 1'b1;
            xfer_on  = 1'b1;
            wait_on  = AW_NONE;
            note_result(OP_IDLE, '0, '0);
          end
          AW_LINE_LOW: begin
            low_hold = d;
            tbl_ptr  = tbl_ptr + 16'd1;
            note_result(OP_READ, table_addr(), '0);
            wait_on = AW_LINE_HIGH;
          end
          default: ;
        endcase
      end
      default: note_result(OP_ERROR, '0, '0);
    endcase
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endtask

  // Offer one transaction after a random gap; predict once it is accepted.
  task automatic send_item(input func_t fn, input logic [7:0] d, input logic en,
                           input logic typed, input op_t typed_op);
    int unsigned gap;
    bus_result_t r;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= fn;
    in_ch.data    <= d;
    in_ch.enabled <= en;
    do @(posedge clk); while (!in_ch.ready);
    advance_channel(fn, d, en);
    if (typed) begin
      r.op   = typed_op;
      r.src  = '0;
      r.dst  = '0;
      r.last = 1'b1;
      awaited_results.push_back(r);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // a stray table byte may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] start, input logic [7:0] bank,
                              input logic [7:0] ibank, input logic [7:0] breg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TABLE_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= REG_TABLE_BANK;
    cfg_wdata <= {8'h00, bank};
    @(posedge clk);
    cfg_index <= REG_INDIRECT_BANK;
    cfg_wdata <= {8'h00, ibank};
    @(posedge clk);
    cfg_index <= REG_B_REGISTER;
    cfg_wdata <= {8'h00, breg};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_table_start = start;
    cfg_table_bank  = bank;
    cfg_ind_bank    = ibank;
    cfg_breg        = breg;
  endtask

  // Counters are mostly short so tables end and repeat often.
  function automatic logic [7:0] pick_table_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (wait_on != AW_INIT_CNT && wait_on != AW_LINE_CNT) return 8'($urandom);
    if (roll < 15) return 8'h00;
    if (roll < 30) return 8'($urandom);
    return {1'($urandom_range(1)), 7'($urandom_range(3, 1))};
  endfunction

  // Act as the bus: answer outstanding reads mostly, mix in events and noise.
  task automatic run_random(input int unsigned target);
    int unsigned answered;
    int unsigned roll;
    func_t       fn;
    logic [7:0]  d;
    logic        en;
    answered = 0;
    while (answered < target) begin
      roll = $urandom_range(99);
      d    = 8'($urandom);
      en   = 1'($urandom_range(1));
      if (wait_on != AW_NONE) begin
        if (roll < 88) begin
          fn = FUNC_DATA;
          d  = pick_table_byte();
        end else if (roll < 94) begin
          fn = FUNC_LINE;
          en = 1'b1;
        end else if (roll < 97) begin
          fn = FUNC_INIT;
          en = 1'b1;
        end else begin
          fn = FUNC_RSVD;
        end
      end else if (!inited || finished) begin
        if (roll < 70) begin
          fn = FUNC_INIT;
          en = (roll < 64);
        end else if (roll < 85) fn = FUNC_LINE;
        else if (roll < 93) fn = FUNC_DATA;
        else fn = FUNC_RSVD;
      end else begin
        if (roll < 80) begin
          fn = FUNC_LINE;
          en = (roll >= 4);
        end else if (roll < 87) begin
          fn = FUNC_INIT;
          en = 1'b1;
        end else if (roll < 94) fn = FUNC_DATA;
        else fn = FUNC_RSVD;
      end
      send_item(fn, d, en, 1'b0, OP_IDLE);
      if (step_results.size() > 0) answered++;
    end
  endtask

  // Result receiver: random stalls, one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(string what, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, got op %0d src %0h dst %0h last %0b", $time,
                 out_ch.op, out_ch.src_address, out_ch.dst_address, out_ch.last);
        mismatches++;
      end else begin
        seen_exp = awaited_results.pop_front();
        check_field("op", 24'(seen_exp.op), 24'(out_ch.op));
        check_field("src_address", seen_exp.src, out_ch.src_address);
        check_field("dst_address", 24'(seen_exp.dst), 24'(out_ch.dst_address));
        check_field("last", 24'(seen_exp.last), 24'(out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mismatches    = 0;
    cycle_count   = 0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    cfg_table_start = '0;
    cfg_table_bank  = '0;
    cfg_ind_bank    = '0;
    cfg_breg        = '0;
    tbl_ptr   = '0;
    line_cnt  = '0;
    ind_ptr   = '0;
    xfer_on   = 1'b0;
    finished  = 1'b0;
    inited    = 1'b0;
    wait_on   = AW_NONE;
    low_hold  = '0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_TABLE_START;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_INIT;
    in_ch.data    <= '0;
    in_ch.enabled <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].fn, directed_rows[i].data, directed_rows[i].en,
                directed_rows[i].typed, directed_rows[i].op);
    end
    wait_idle();

    program_regs(16'h0000, 8'h00, 8'h00, 8'h00);
    run_random(PHASE_ITEMS);
    wait_idle();

    // no idling on either side for this phase
    program_regs(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    calm = 1'b1;
    run_random(PHASE_ITEMS);
    calm = 1'b0;
    wait_idle();

    // hold the result side off so the job queue fills and backpressures
    program_regs(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    hold_off_req = 1'b1;
    run_random(PHASE_ITEMS);
    wait_idle();

    program_regs(16'hFFFE, 8'($urandom), 8'($urandom), 8'hFF);
    run_random(PHASE_ITEMS);
    wait_idle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/hdi_pkg.sv
design/hdi_in_if.sv
design/hdi_out_if.sv
design/hdi_front.sv
design/hdi_queue.sv
design/hdi_back.sv
design/hdma_indirect_channel.sv
design/hdi_checker.sv
bench/tb_top.sv
